// ===== rtl/core/ecd_pkg.sv =====
// ----------------------------------------------------------------------------
// ecd_pkg
// Shared constants and types of the echo filter convergence detector.
// ----------------------------------------------------------------------------
package ecd_pkg;

   localparam int LEVEL_WIDTH     = 40;
   localparam int CHANNEL_WIDTH   = 3;
   localparam int CSR_INDEX_WIDTH = 8;
   localparam int QUEUE_DEPTH     = 4;
   localparam int NUM_ENERGIES    = 3;
   localparam int SMOOTH_SHIFT    = 16;
   localparam int GAIN_WIDTH      = 16;

   // 0.4 in Q16
   localparam logic [GAIN_WIDTH-1:0] SMOOTH_GAIN = 16'd26214;

   localparam logic                   SMOOTH_ENABLE_RST      = 1'b1;
   localparam logic [LEVEL_WIDTH-1:0] CONVERGE_LEVEL_RST     = 40'd160000;
   localparam logic [LEVEL_WIDTH-1:0] LOW_CONVERGE_LEVEL_RST = 40'd25600;
   localparam logic [LEVEL_WIDTH-1:0] DIVERGE_LEVEL_RST      = 40'd57600;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_SMOOTH_ENABLE      = 8'd0,
      CSR_CONVERGE_LEVEL     = 8'd1,
      CSR_LOW_CONVERGE_LEVEL = 8'd2,
      CSR_DIVERGE_LEVEL      = 8'd3
   } csr_index_type;

   typedef struct packed {
      logic                   smooth_enable;
      logic [LEVEL_WIDTH-1:0] converge_level;
      logic [LEVEL_WIDTH-1:0] low_converge_level;
      logic [LEVEL_WIDTH-1:0] diverge_level;
   } cfg_type;

   typedef struct packed {
      logic channel_converged;
      logic channel_coarse_relaxed;
      logic channel_diverged;
      logic any_converged;
      logic any_coarse_converged;
      logic all_diverged;
      logic block_done;
   } rsp_flags_type;

   typedef enum logic [1:0] {
      EN_CAPTURE = 2'd0,
      EN_REFINED = 2'd1,
      EN_COARSE  = 2'd2
   } energy_sel_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_DIFF,
      BK_MUL,
      BK_ADJ,
      BK_FLAG,
      BK_DONE
   } back_state_type;

endpackage

// ===== rtl/core/ecd_channels_if.sv =====
// ----------------------------------------------------------------------------
// ecd channel interfaces
// Valid/ready channels for energy requests, flag responses and CSR writes.
// ----------------------------------------------------------------------------
interface ecd_req_if #(
   parameter int ENERGY_WIDTH = 40
);
   logic                               valid;
   logic                               ready;
   logic [ecd_pkg::CHANNEL_WIDTH-1:0]  channel;
   logic [ENERGY_WIDTH-1:0]            capture_energy;
   logic [ENERGY_WIDTH-1:0]            refined_error_energy;
   logic [ENERGY_WIDTH-1:0]            coarse_error_energy;
   logic                               final_channel;

   modport source (
      output valid, channel, capture_energy, refined_error_energy,
             coarse_error_energy, final_channel,
      input  ready
   );
   modport sink (
      input  valid, channel, capture_energy, refined_error_energy,
             coarse_error_energy, final_channel,
      output ready
   );
endinterface

interface ecd_rsp_if;
   logic valid;
   logic ready;
   logic channel_converged;
   logic channel_coarse_relaxed;
   logic channel_diverged;
   logic any_converged;
   logic any_coarse_converged;
   logic all_diverged;
   logic block_done;

   modport source (
      output valid, channel_converged, channel_coarse_relaxed, channel_diverged,
             any_converged, any_coarse_converged, all_diverged, block_done,
      input  ready
   );
   modport sink (
      input  valid, channel_converged, channel_coarse_relaxed, channel_diverged,
             any_converged, any_coarse_converged, all_diverged, block_done,
      output ready
   );
endinterface

interface ecd_csr_if;
   logic                                valid;
   logic                                ready;
   logic [ecd_pkg::CSR_INDEX_WIDTH-1:0] index;
   logic [ecd_pkg::LEVEL_WIDTH-1:0]     data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/ecd_front.sv =====
// ----------------------------------------------------------------------------
// ecd_front
// Accepts energy transactions and classifies the raw-energy flags.
// ----------------------------------------------------------------------------
module ecd_front #(
   parameter int ENERGY_WIDTH = 40,
   localparam int ITEM_WIDTH = ecd_pkg::CHANNEL_WIDTH + 3 * ENERGY_WIDTH + 3
) (
   input  logic                  clock,
   input  logic                  reset,
   input  ecd_pkg::cfg_type      cfg,
   ecd_req_if.sink               req_chan,
   output logic                  push_valid,
   input  logic                  push_ready,
   output logic [ITEM_WIDTH-1:0] push_item
);
   localparam int CMP_WIDTH = (ENERGY_WIDTH > ecd_pkg::LEVEL_WIDTH) ?
                              ENERGY_WIDTH : ecd_pkg::LEVEL_WIDTH;

   logic                              s1_valid_ff, s1_valid_in;
   logic [ecd_pkg::CHANNEL_WIDTH-1:0] s1_channel_ff, s1_channel_in;
   logic [ENERGY_WIDTH-1:0]           s1_y_ff, s1_y_in;
   logic [ENERGY_WIDTH-1:0]           s1_er_ff, s1_er_in;
   logic [ENERGY_WIDTH-1:0]           s1_ec_ff, s1_ec_in;
   logic                              s1_last_ff, s1_last_in;
   logic [ENERGY_WIDTH+2:0]           s1_ec5_ff, s1_ec5_in;
   logic [ENERGY_WIDTH+1:0]           s1_y3_ff, s1_y3_in;
   logic [ENERGY_WIDTH:0]             s1_min2_ff, s1_min2_in;
   logic [ENERGY_WIDTH-1:0]           min_err;
   logic                              accept;
   logic                              y_above_low;
   logic                              y_above_div;
   logic                              relaxed;
   logic                              diverged;

   assign req_chan.ready = !s1_valid_ff || push_ready;
   assign accept         = req_chan.valid && req_chan.ready;
   assign min_err        = (req_chan.refined_error_energy < req_chan.coarse_error_energy) ?
                           req_chan.refined_error_energy : req_chan.coarse_error_energy;

   always_comb begin
      s1_valid_in   = s1_valid_ff;
      s1_channel_in = s1_channel_ff;
      s1_y_in       = s1_y_ff;
      s1_er_in      = s1_er_ff;
      s1_ec_in      = s1_ec_ff;
      s1_last_in    = s1_last_ff;
      s1_ec5_in     = s1_ec5_ff;
      s1_y3_in      = s1_y3_ff;
      s1_min2_in    = s1_min2_ff;
      if (req_chan.ready) begin
         s1_valid_in = req_chan.valid;
      end
      if (accept) begin
         s1_channel_in = req_chan.channel;
         s1_y_in       = req_chan.capture_energy;
         s1_er_in      = req_chan.refined_error_energy;
         s1_ec_in      = req_chan.coarse_error_energy;
         s1_last_in    = req_chan.final_channel;
         s1_ec5_in     = (ENERGY_WIDTH+3)'({req_chan.coarse_error_energy, 2'b00}) +
                         (ENERGY_WIDTH+3)'(req_chan.coarse_error_energy);
         s1_y3_in      = (ENERGY_WIDTH+2)'({req_chan.capture_energy, 1'b0}) +
                         (ENERGY_WIDTH+2)'(req_chan.capture_energy);
         s1_min2_in    = {min_err, 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_channel_ff <= s1_channel_in;
      s1_y_ff       <= s1_y_in;
      s1_er_ff      <= s1_er_in;
      s1_ec_ff      <= s1_ec_in;
      s1_last_ff    <= s1_last_in;
      s1_ec5_ff     <= s1_ec5_in;
      s1_y3_ff      <= s1_y3_in;
      s1_min2_ff    <= s1_min2_in;
   end

   assign y_above_low = CMP_WIDTH'(s1_y_ff) > CMP_WIDTH'(cfg.low_converge_level);
   assign y_above_div = CMP_WIDTH'(s1_y_ff) > CMP_WIDTH'(cfg.diverge_level);
   assign relaxed     = (s1_ec5_ff < (ENERGY_WIDTH+3)'(s1_y_ff)) && y_above_low;
   assign diverged    = ((ENERGY_WIDTH+2)'(s1_min2_ff) > s1_y3_ff) && y_above_div;

   assign push_valid = s1_valid_ff;
   assign push_item  = {s1_channel_ff, s1_y_ff, s1_er_ff, s1_ec_ff,
                        s1_last_ff, relaxed, diverged};

endmodule

// ===== rtl/core/ecd_queue.sv =====
// ----------------------------------------------------------------------------
// ecd_queue
// Short FIFO between the classifying front and the smoothing back end.
// ----------------------------------------------------------------------------
module ecd_queue #(
   parameter int WIDTH = 126
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_item,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_item
);
   localparam int PTR_WIDTH = $clog2(ecd_pkg::QUEUE_DEPTH);

   logic [WIDTH-1:0]     slot_ff [ecd_pkg::QUEUE_DEPTH];
   logic [WIDTH-1:0]     slot_in [ecd_pkg::QUEUE_DEPTH];
   logic [PTR_WIDTH-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_WIDTH-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_WIDTH:0]   count_ff, count_in;
   logic                 do_push;
   logic                 do_pop;

   assign push_ready = count_ff != (PTR_WIDTH+1)'(ecd_pkg::QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_item   = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      slot_in   = slot_ff;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         slot_in[wr_ptr_ff] = push_item;
         wr_ptr_in          = wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + (PTR_WIDTH+1)'(do_push) - (PTR_WIDTH+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
   end

endmodule

// ===== rtl/core/ecd_back.sv =====
// ----------------------------------------------------------------------------
// ecd_back
// Smooths per-channel energies on one shared multiplier, derives the
// convergence flag, folds the block aggregates and holds the response.
// ----------------------------------------------------------------------------
module ecd_back #(
   parameter int NUM_CHANNELS = 8,
   parameter int ENERGY_WIDTH = 40,
   localparam int ITEM_WIDTH = ecd_pkg::CHANNEL_WIDTH + 3 * ENERGY_WIDTH + 3
) (
   input  logic                  clock,
   input  logic                  reset,
   input  ecd_pkg::cfg_type      cfg,
   input  logic                  pop_valid,
   output logic                  pop_ready,
   input  logic [ITEM_WIDTH-1:0] pop_item,
   ecd_rsp_if.source             rsp_chan
);
   localparam int E           = ENERGY_WIDTH;
   localparam int MAX_CH      = 1 << ecd_pkg::CHANNEL_WIDTH;
   localparam int STORE_DEPTH = (NUM_CHANNELS < MAX_CH) ? NUM_CHANNELS : MAX_CH;
   localparam int SIDX_WIDTH  = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
   localparam int CMP_WIDTH   = (E > ecd_pkg::LEVEL_WIDTH) ? E : ecd_pkg::LEVEL_WIDTH;
   localparam int PROD_WIDTH  = E + ecd_pkg::GAIN_WIDTH;
   localparam int NE          = ecd_pkg::NUM_ENERGIES;

   ecd_pkg::back_state_type state_ff, state_in;
   ecd_pkg::energy_sel_type sel_ff, sel_in;
   ecd_pkg::rsp_flags_type  rsp_flags_ff, rsp_flags_in;
   logic                    rsp_valid_ff, rsp_valid_in;

   logic [E-1:0]            store_ff [NE][STORE_DEPTH];
   logic [E-1:0]            store_in [NE][STORE_DEPTH];
   logic [E-1:0]            raw_ff [NE];
   logic [E-1:0]            raw_in [NE];
   logic [E-1:0]            sm_ff [NE];
   logic [E-1:0]            sm_in [NE];
   logic [E-1:0]            head_raw [NE];

   logic [SIDX_WIDTH-1:0]   idx_ff, idx_in;
   logic                    in_range_ff, in_range_in;
   logic                    last_ff, last_in;
   logic                    relaxed_ff, relaxed_in;
   logic                    div_ff, div_in;
   logic [E-1:0]            diff_ff, diff_in;
   logic                    neg_ff, neg_in;
   logic [PROD_WIDTH-1:0]   prod_ff, prod_in;
   logic                    c2_ff, c2_in;
   logic                    gt_ff, gt_in;
   logic [E+4:0]            t20_ff, t20_in;
   logic                    run_conv_ff, run_conv_in;
   logic                    run_coarse_ff, run_coarse_in;
   logic                    run_div_ff, run_div_in;

   logic [ecd_pkg::CHANNEL_WIDTH-1:0] head_channel;
   logic                    head_last;
   logic                    head_relaxed;
   logic                    head_div;
   logic                    head_in_range;
   logic [SIDX_WIDTH-1:0]   head_idx;
   logic                    start;
   logic                    finish;
   logic                    slot_free;
   logic [E-1:0]            u_sel;
   logic [E-1:0]            s_sel;
   logic [E-1:0]            mag;
   logic                    rem;
   logic [E-1:0]            adj_value;
   logic                    conv;
   logic                    any_conv;
   logic                    any_coarse;
   logic                    all_div;

   assign head_div                      = pop_item[0];
   assign head_relaxed                  = pop_item[1];
   assign head_last                     = pop_item[2];
   assign head_raw[ecd_pkg::EN_COARSE]  = pop_item[3 +: E];
   assign head_raw[ecd_pkg::EN_REFINED] = pop_item[3 + E +: E];
   assign head_raw[ecd_pkg::EN_CAPTURE] = pop_item[3 + 2 * E +: E];
   assign head_channel = pop_item[3 + 3 * E +: ecd_pkg::CHANNEL_WIDTH];
   assign head_in_range = 32'(head_channel) < 32'(NUM_CHANNELS);
   assign head_idx      = head_channel[SIDX_WIDTH-1:0];

   assign slot_free = !rsp_valid_ff || rsp_chan.ready;
   assign start     = pop_valid && pop_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ecd_pkg::BK_IDLE: begin
            if (pop_valid) begin
               state_in = (cfg.smooth_enable && head_in_range) ?
                          ecd_pkg::BK_DIFF : ecd_pkg::BK_FLAG;
            end
         end
         ecd_pkg::BK_DIFF: state_in = ecd_pkg::BK_MUL;
         ecd_pkg::BK_MUL:  state_in = ecd_pkg::BK_ADJ;
         ecd_pkg::BK_ADJ: begin
            state_in = (sel_ff == ecd_pkg::EN_COARSE) ? ecd_pkg::BK_FLAG : ecd_pkg::BK_DIFF;
         end
         ecd_pkg::BK_FLAG: state_in = ecd_pkg::BK_DONE;
         ecd_pkg::BK_DONE: begin
            if (slot_free) begin
               state_in = ecd_pkg::BK_IDLE;
            end
         end
         default: state_in = ecd_pkg::BK_IDLE;
      endcase
   end

   always_comb begin
      pop_ready = 1'b0;
      finish    = 1'b0;
      unique case (state_ff)
         ecd_pkg::BK_IDLE: pop_ready = 1'b1;
         ecd_pkg::BK_DONE: finish    = slot_free;
         default: ;
      endcase
   end

   // one smoothing step: s + floor((u - s) * gain / 2^16)
   assign u_sel     = raw_ff[sel_ff];
   assign s_sel     = sm_ff[sel_ff];
   assign mag       = prod_ff[ecd_pkg::SMOOTH_SHIFT +: E];
   assign rem       = |prod_ff[ecd_pkg::SMOOTH_SHIFT-1:0];
   assign adj_value = neg_ff ? (s_sel - mag - E'(rem)) : (s_sel + mag);

   assign conv       = (c2_ff || (t20_ff < (E+5)'(sm_ff[ecd_pkg::EN_CAPTURE]))) && gt_ff;
   assign any_conv   = run_conv_ff || conv;
   assign any_coarse = run_coarse_ff || relaxed_ff;
   assign all_div    = run_div_ff && div_ff;

   always_comb begin
      sel_in      = sel_ff;
      raw_in      = raw_ff;
      sm_in       = sm_ff;
      idx_in      = idx_ff;
      in_range_in = in_range_ff;
      last_in     = last_ff;
      relaxed_in  = relaxed_ff;
      div_in      = div_ff;
      neg_in      = neg_ff;
      diff_in     = diff_ff;
      prod_in     = prod_ff;
      c2_in       = c2_ff;
      gt_in       = gt_ff;
      t20_in      = t20_ff;
      if (start) begin
         sel_in      = ecd_pkg::EN_CAPTURE;
         raw_in      = head_raw;
         idx_in      = head_idx;
         in_range_in = head_in_range;
         last_in     = head_last;
         relaxed_in  = head_relaxed;
         div_in      = head_div;
         for (int k = 0; k < NE; k++) begin
            sm_in[k] = (cfg.smooth_enable && head_in_range) ?
                       store_ff[k][head_idx] : head_raw[k];
         end
      end
      if (state_ff == ecd_pkg::BK_DIFF) begin
         neg_in  = u_sel < s_sel;
         diff_in = (u_sel < s_sel) ? (s_sel - u_sel) : (u_sel - s_sel);
      end
      if (state_ff == ecd_pkg::BK_MUL) begin
         prod_in = PROD_WIDTH'(diff_ff) * PROD_WIDTH'(ecd_pkg::SMOOTH_GAIN);
      end
      if (state_ff == ecd_pkg::BK_ADJ) begin
         sm_in[sel_ff] = adj_value;
         case (sel_ff)
            ecd_pkg::EN_CAPTURE: sel_in = ecd_pkg::EN_REFINED;
            ecd_pkg::EN_REFINED: sel_in = ecd_pkg::EN_COARSE;
            default:             sel_in = ecd_pkg::EN_COARSE;
         endcase
      end
      if (state_ff == ecd_pkg::BK_FLAG) begin
         c2_in  = {sm_ff[ecd_pkg::EN_REFINED], 1'b0} < (E+1)'(sm_ff[ecd_pkg::EN_CAPTURE]);
         t20_in = (E+5)'({sm_ff[ecd_pkg::EN_COARSE], 4'b0000}) +
                  (E+5)'({sm_ff[ecd_pkg::EN_COARSE], 2'b00});
         gt_in  = CMP_WIDTH'(sm_ff[ecd_pkg::EN_CAPTURE]) > CMP_WIDTH'(cfg.converge_level);
      end
   end

   always_comb begin
      store_in      = store_ff;
      run_conv_in   = run_conv_ff;
      run_coarse_in = run_coarse_ff;
      run_div_in    = run_div_ff;
      rsp_flags_in  = rsp_flags_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      if (finish) begin
         if (in_range_ff) begin
            for (int k = 0; k < NE; k++) begin
               store_in[k][idx_ff] = sm_ff[k];
            end
         end
         rsp_valid_in                        = 1'b1;
         rsp_flags_in.channel_converged      = conv;
         rsp_flags_in.channel_coarse_relaxed = relaxed_ff;
         rsp_flags_in.channel_diverged       = div_ff;
         rsp_flags_in.any_converged          = any_conv;
         rsp_flags_in.any_coarse_converged   = any_coarse;
         rsp_flags_in.all_diverged           = all_div;
         rsp_flags_in.block_done             = last_ff;
         run_conv_in   = !last_ff && any_conv;
         run_coarse_in = !last_ff && any_coarse;
         run_div_in    = last_ff || all_div;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ecd_pkg::BK_IDLE;
         sel_ff        <= ecd_pkg::EN_CAPTURE;
         rsp_valid_ff  <= 1'b0;
         run_conv_ff   <= 1'b0;
         run_coarse_ff <= 1'b0;
         run_div_ff    <= 1'b1;
         store_ff      <= '{default: '0};
      end else begin
         state_ff      <= state_in;
         sel_ff        <= sel_in;
         rsp_valid_ff  <= rsp_valid_in;
         run_conv_ff   <= run_conv_in;
         run_coarse_ff <= run_coarse_in;
         run_div_ff    <= run_div_in;
         store_ff      <= store_in;
      end
   end

   always_ff @(posedge clock) begin
      raw_ff       <= raw_in;
      sm_ff        <= sm_in;
      idx_ff       <= idx_in;
      in_range_ff  <= in_range_in;
      last_ff      <= last_in;
      relaxed_ff   <= relaxed_in;
      div_ff       <= div_in;
      neg_ff       <= neg_in;
      diff_ff      <= diff_in;
      prod_ff      <= prod_in;
      c2_ff        <= c2_in;
      gt_ff        <= gt_in;
      t20_ff       <= t20_in;
      rsp_flags_ff <= rsp_flags_in;
   end

   assign rsp_chan.valid                  = rsp_valid_ff;
   assign rsp_chan.channel_converged      = rsp_flags_ff.channel_converged;
   assign rsp_chan.channel_coarse_relaxed = rsp_flags_ff.channel_coarse_relaxed;
   assign rsp_chan.channel_diverged       = rsp_flags_ff.channel_diverged;
   assign rsp_chan.any_converged          = rsp_flags_ff.any_converged;
   assign rsp_chan.any_coarse_converged   = rsp_flags_ff.any_coarse_converged;
   assign rsp_chan.all_diverged           = rsp_flags_ff.all_diverged;
   assign rsp_chan.block_done             = rsp_flags_ff.block_done;

   a_start_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      start |=> state_ff != ecd_pkg::BK_IDLE)
      else $error("back end stayed idle after taking a queued transaction");

   a_smooth_bounded: assert property (@(posedge clock) disable iff (reset)
      state_ff == ecd_pkg::BK_ADJ |->
         (neg_ff ? (adj_value <= s_sel && adj_value >= u_sel)
                 : (adj_value >= s_sel && adj_value <= u_sel)))
      else $error("smoothed energy left the interval of old and raw value");

   a_finish_shows_rsp: assert property (@(posedge clock) disable iff (reset)
      finish |=> rsp_valid_ff)
      else $error("finished transaction not presented on the response channel");

   a_aggregates_cover_channel: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |->
         (!rsp_flags_ff.channel_converged || rsp_flags_ff.any_converged) &&
         (!rsp_flags_ff.channel_coarse_relaxed || rsp_flags_ff.any_coarse_converged) &&
         (!rsp_flags_ff.all_diverged || rsp_flags_ff.channel_diverged))
      else $error("block aggregates disagree with the channel flags");

endmodule

// ===== rtl/core/echo_filter_convergence_detector_core.sv =====
// ----------------------------------------------------------------------------
// echo_filter_convergence_detector_core
// Per-channel convergence, relaxed coarse and divergence flags from block
// energies, with optional per-channel smoothing and block aggregates.
//
//   channel   role     handshake      payload
//   req_chan  sink     valid/ready    channel, three energies, final_channel
//   rsp_chan  source   valid/ready    three channel flags, three aggregates, block_done
//   csr_chan  sink     valid/ready    register index, write data
//
// The front takes one transaction per cycle into a stage register and a
// four-entry queue unless a full queue holds the stage register. The back end
// works on one transaction at a time: three smoothing steps (difference,
// multiply, adjust) on one shared multiplier with smoothing on, none with it
// off or a channel out of range. Reset is synchronous; it clears smoothed
// energies, resets aggregates and loads register defaults, with no clearing
// pass. A stalled response holds in its output register while the front fills the queue.
// ----------------------------------------------------------------------------
module echo_filter_convergence_detector_core #(
   parameter int NUM_CHANNELS = 8,
   parameter int ENERGY_WIDTH = 40
) (
   input logic        clock,
   input logic        reset,
   ecd_req_if.sink    req_chan,
   ecd_rsp_if.source  rsp_chan,
   ecd_csr_if.sink    csr_chan
);
   localparam int ITEM_WIDTH = ecd_pkg::CHANNEL_WIDTH + 3 * ENERGY_WIDTH + 3;

   ecd_pkg::cfg_type      cfg_ff, cfg_in;
   logic                  push_valid;
   logic                  push_ready;
   logic [ITEM_WIDTH-1:0] push_item;
   logic                  pop_valid;
   logic                  pop_ready;
   logic [ITEM_WIDTH-1:0] pop_item;

   assign csr_chan.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_chan.valid) begin
         unique case (csr_chan.index)
            ecd_pkg::CSR_SMOOTH_ENABLE:      cfg_in.smooth_enable      = csr_chan.data[0];
            ecd_pkg::CSR_CONVERGE_LEVEL:     cfg_in.converge_level     = csr_chan.data;
            ecd_pkg::CSR_LOW_CONVERGE_LEVEL: cfg_in.low_converge_level = csr_chan.data;
            ecd_pkg::CSR_DIVERGE_LEVEL:      cfg_in.diverge_level      = csr_chan.data;
            default:                         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.smooth_enable      <= ecd_pkg::SMOOTH_ENABLE_RST;
         cfg_ff.converge_level     <= ecd_pkg::CONVERGE_LEVEL_RST;
         cfg_ff.low_converge_level <= ecd_pkg::LOW_CONVERGE_LEVEL_RST;
         cfg_ff.diverge_level      <= ecd_pkg::DIVERGE_LEVEL_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   ecd_front #(
      .ENERGY_WIDTH (ENERGY_WIDTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_chan   (req_chan),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item)
   );

   ecd_queue #(
      .WIDTH (ITEM_WIDTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   ecd_back #(
      .NUM_CHANNELS (NUM_CHANNELS),
      .ENERGY_WIDTH (ENERGY_WIDTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_item  (pop_item),
      .rsp_chan  (rsp_chan)
   );

endmodule
